// ----- sv/quaternion_arithmetic_unit_defines.svh -----
`ifndef QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH
`define QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define QAU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quaternion unit check failed");

// Check that cons holds in the cycle after ante.
`define QAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quaternion unit check failed");

`endif

// ----- sv/qau_pkg.sv -----
`default_nettype none

package qau_pkg;

  // Component format: signed fixed point, Q4.27
  localparam int COMP_WIDTH = 32;
  localparam int FRAC_BITS  = 27;

  // Products per component and component lanes
  localparam int TERMS     = 4;
  localparam int NUM_LANES = 4;
  localparam int IDX_W     = $clog2(TERMS);

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic signed [COMP_WIDTH:0]   lin_t;

  localparam comp_t COMP_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
  localparam comp_t COMP_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    ACT_ADD   = 3'd0,
    ACT_SUB   = 3'd1,
    ACT_HAM   = 3'd2,
    ACT_SCALE = 3'd3,
    ACT_CONJ  = 3'd4,
    ACT_NEG   = 3'd5
  } action_e;

  // Hamilton product: term k of component c is a[k] * b[c ^ k]; a set bit subtracts it
  localparam logic [TERMS-1:0] HAM_NEG [NUM_LANES] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

  typedef struct packed {
    action_e action;
    comp_t   a_w;
    comp_t   a_x;
    comp_t   a_y;
    comp_t   a_z;
    comp_t   b_w;
    comp_t   b_x;
    comp_t   b_y;
    comp_t   b_z;
    comp_t   factor;
  } qau_req_t;

  typedef struct packed {
    comp_t r_w;
    comp_t r_x;
    comp_t r_y;
    comp_t r_z;
    logic  overflow;
  } qau_rsp_t;

  // Load enables of the lane pipeline stages
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } lane_en_t;

endpackage

`default_nettype wire

// ----- sv/qau_lane.sv -----
`default_nettype none

module qau_lane import qau_pkg::*; (
  input  logic             clk_i,
  input  lane_en_t         en_i,
  input  comp_t            mx_i [TERMS],
  input  comp_t            my_i [TERMS],
  input  logic [TERMS-1:0] neg_i,
  input  lin_t             lin_i,
  input  logic             shift_i,
  output comp_t            r_o,
  output logic             ovf_o
);

  // Second operand is split into a signed upper part and an unsigned lower part
  localparam int LO_W  = COMP_WIDTH / 2;
  localparam int HI_W  = COMP_WIDTH - LO_W;
  localparam int PH_W  = COMP_WIDTH + HI_W;
  localparam int PL_W  = COMP_WIDTH + LO_W + 1;
  localparam int SH_W  = PH_W + 2;
  localparam int SL_W  = PL_W + 3;
  localparam int TOT_W = 2 * COMP_WIDTH + 3;

  logic signed [PH_W-1:0]  ph_d [TERMS];
  logic signed [PH_W-1:0]  ph_q [TERMS];
  logic signed [PL_W-1:0]  pl_d [TERMS];
  logic signed [PL_W-1:0]  pl_q [TERMS];
  logic [TERMS-1:0]        neg_q;
  lin_t                    lin_q;
  logic                    shift2_q;
  logic signed [SH_W-1:0]  sh_d;
  logic signed [SH_W-1:0]  sh_q;
  logic signed [SL_W-1:0]  sl_d;
  logic signed [SL_W-1:0]  sl_q;
  logic                    shift3_q;
  logic signed [TOT_W-1:0] tot;
  logic signed [TOT_W-1:0] scaled;
  logic [TOT_W-COMP_WIDTH:0] upper;
  comp_t                   r_d;
  comp_t                   r_q;
  logic                    ovf_d;
  logic                    ovf_q;

  // Form the partial products of each term
  always_comb begin
    logic signed [HI_W-1:0] yh;
    logic signed [LO_W:0]   yl;
    for (int k = 0; k < TERMS; k++) begin
      yh = my_i[k][COMP_WIDTH-1:LO_W];
      yl = {1'b0, my_i[k][LO_W-1:0]};
      ph_d[k] = PH_W'(mx_i[k]) * PH_W'(yh);
      pl_d[k] = PL_W'(mx_i[k]) * PL_W'(yl);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      ph_q     <= ph_d;
      pl_q     <= pl_d;
      neg_q    <= neg_i;
      lin_q    <= lin_i;
      shift2_q <= shift_i;
    end
  end

  // Sum upper and lower partial products separately, with the linear term
  always_comb begin
    sh_d = '0;
    sl_d = SL_W'(lin_q);
    for (int k = 0; k < TERMS; k++) begin
      if (neg_q[k]) begin
        sh_d = sh_d - SH_W'(ph_q[k]);
        sl_d = sl_d - SL_W'(pl_q[k]);
      end else begin
        sh_d = sh_d + SH_W'(ph_q[k]);
        sl_d = sl_d + SL_W'(pl_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      sh_q     <= sh_d;
      sl_q     <= sl_d;
      shift3_q <= shift2_q;
    end
  end

  // Merge the halves, drop the fraction of a product, saturate
  always_comb begin
    tot    = (TOT_W'(sh_q) <<< LO_W) + TOT_W'(sl_q);
    scaled = shift3_q ? (tot >>> FRAC_BITS) : tot;
    upper  = scaled[TOT_W-1:COMP_WIDTH-1];
    ovf_d  = !((&upper) || !(|upper));
    if (!ovf_d) begin
      r_d = scaled[COMP_WIDTH-1:0];
    end else if (scaled[TOT_W-1]) begin
      r_d = COMP_MIN;
    end else begin
      r_d = COMP_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      r_q   <= r_d;
      ovf_q <= ovf_d;
    end
  end

  assign r_o   = r_q;
  assign ovf_o = ovf_q;

endmodule

`default_nettype wire

// ----- sv/quaternion_arithmetic_unit.sv -----
// Quaternion ALU: add, subtract, Hamilton product, scale, conjugate, negate.
// Pipeline: an accepted request passes through 4 register stages before its result is presented.
// Throughput: one request per cycle unless out_stall_i holds a full pipeline; stage 2 takes 32x16 partial products.
// A stalled output holds its result while the earlier stages keep filling their bubbles.
// Reset (rst_ni low, asynchronous) clears the stage valid bits only; data registers keep state.
`default_nettype none
`include "quaternion_arithmetic_unit_defines.svh"

module quaternion_arithmetic_unit import qau_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  qau_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output qau_rsp_t out_rsp_o
);

  localparam int STAGES = 4;

  logic [STAGES-1:0] valid_d;
  logic [STAGES-1:0] valid_q;
  logic [STAGES-1:0] adv;
  lane_en_t          lane_en;
  qau_req_t          req_q;

  comp_t            a [TERMS];
  comp_t            b [TERMS];
  logic             is_ham;
  logic             is_scale;
  comp_t            r     [NUM_LANES];
  logic             ovf   [NUM_LANES];
  logic             rsp_sat;

  // Advance a stage when it is empty or the stage after it advances
  always_comb begin
    adv[STAGES-1] = !valid_q[STAGES-1] || !out_stall_i;
    for (int s = STAGES - 2; s >= 0; s--) begin
      adv[s] = !valid_q[s] || adv[s+1];
    end
    valid_d[0] = adv[0] ? in_valid_i : valid_q[0];
    for (int s = 1; s < STAGES; s++) begin
      valid_d[s] = adv[s] ? valid_q[s-1] : valid_q[s];
    end
    lane_en.s2 = adv[1] && valid_q[0];
    lane_en.s3 = adv[2] && valid_q[1];
    lane_en.s4 = adv[3] && valid_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (in_valid_i && adv[0]) begin
      req_q <= in_req_i;
    end
  end

  assign in_stall_o = !adv[0];

  // Decode the action
  always_comb begin
    a[0] = req_q.a_w;
    a[1] = req_q.a_x;
    a[2] = req_q.a_y;
    a[3] = req_q.a_z;
    b[0] = req_q.b_w;
    b[1] = req_q.b_x;
    b[2] = req_q.b_y;
    b[3] = req_q.b_z;
    is_ham   = 1'b0;
    is_scale = 1'b0;
    unique case (req_q.action)
      ACT_HAM:   is_ham   = 1'b1;
      ACT_SCALE: is_scale = 1'b1;
      default:   ;
    endcase
  end

  for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
    comp_t            mx [TERMS];
    comp_t            my [TERMS];
    logic [TERMS-1:0] neg;
    lin_t             lin;

    // Select multiplier operands and the linear term of this component
    always_comb begin
      logic [IDX_W-1:0] bi;
      for (int k = 0; k < TERMS; k++) begin
        bi = IDX_W'(c) ^ IDX_W'(k);
        if (is_ham) begin
          mx[k] = a[k];
          my[k] = b[bi];
        end else if (is_scale && k == 0) begin
          mx[k] = a[c];
          my[k] = req_q.factor;
        end else begin
          mx[k] = '0;
          my[k] = '0;
        end
      end
      neg = is_ham ? HAM_NEG[c] : '0;
      case (req_q.action)
        ACT_ADD:  lin = lin_t'(a[c]) + lin_t'(b[c]);
        ACT_SUB:  lin = lin_t'(a[c]) - lin_t'(b[c]);
        ACT_CONJ: lin = (c == 0) ? lin_t'(a[c]) : -lin_t'(a[c]);
        ACT_NEG:  lin = -lin_t'(a[c]);
        default:  lin = '0;
      endcase
    end

    qau_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (lane_en),
      .mx_i    (mx),
      .my_i    (my),
      .neg_i   (neg),
      .lin_i   (lin),
      .shift_i (is_ham || is_scale),
      .r_o     (r[c]),
      .ovf_o   (ovf[c])
    );
  end

  // Assemble the response
  always_comb begin
    out_rsp_o.r_w      = r[0];
    out_rsp_o.r_x      = r[1];
    out_rsp_o.r_y      = r[2];
    out_rsp_o.r_z      = r[3];
    out_rsp_o.overflow = ovf[0] || ovf[1] || ovf[2] || ovf[3];
  end

  assign out_valid_o = valid_q[STAGES-1];

  // Flag a response that holds a saturated component
  assign rsp_sat = (out_rsp_o.r_w == COMP_MAX) || (out_rsp_o.r_w == COMP_MIN) ||
                   (out_rsp_o.r_x == COMP_MAX) || (out_rsp_o.r_x == COMP_MIN) ||
                   (out_rsp_o.r_y == COMP_MAX) || (out_rsp_o.r_y == COMP_MIN) ||
                   (out_rsp_o.r_z == COMP_MAX) || (out_rsp_o.r_z == COMP_MIN);

  // An accepted request always lands in the first stage
  `QAU_ASSERT_NEXT(a_accept_fills, clk_i, rst_ni, in_valid_i && !in_stall_o, valid_q[0])
  // Back pressure reaches the input only with every stage full and the output stalled
  `QAU_ASSERT_IMPL(a_stall_full, clk_i, rst_ni, in_stall_o, (&valid_q) && out_stall_i)
  // A flagged result carries at least one saturated component
  `QAU_ASSERT_IMPL(a_ovf_sat, clk_i, rst_ni, out_valid_o && out_rsp_o.overflow, rsp_sat)

endmodule

`default_nettype wire
